>>> rtl/core/integer_to_radix_text_core_assert.svh
// Assertion macros for the radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITRT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/itrt_pkg.sv
// Shared constants and the digit glyph function of the radix text converter.
package itrt_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = VALUE_WIDTH / BITS_PER_STEP;
	localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CNT_W         = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W         = $clog2(VALUE_WIDTH);
	localparam int RADIX_W       = 6;
	localparam int DIGIT_W       = 6;
	localparam int CHAR_W        = 7;
	localparam int OUT_DATA_W    = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h61;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'h2d;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

	function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] digit);
		logic [CHAR_W-1:0] d7;
		d7 = {1'b0, digit};
		if (digit < DEC_DIGITS) begin
			glyph_of = CHAR_ZERO + d7;
		end else begin
			glyph_of = CHAR_A + d7 - {1'b0, DEC_DIGITS};
		end
	endfunction

endpackage

>>> rtl/core/integer_to_radix_text_core.sv
// Signed integer to ASCII text converter in a base of 2 to 36, one character per beat.
// Each digit is divided out of the running quotient by the shared divider (4 quotient bits
//   per cycle), then an optional minus sign is sent and the digits follow, most significant first.
// One value at a time: a new value is accepted only once the previous value's last
//   character has entered the output register.
// Reset (arst_n low, async): idle, no beat pending, radix 16; digit store is never cleared.
`include "integer_to_radix_text_core_assert.svh"

module integer_to_radix_text_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// radix register write
	input  logic                                     radix_we,
	input  logic [itrt_pkg::RADIX_W-1:0]             radix_wdata,
	// input stream; tdata: value[31:0]
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic signed [itrt_pkg::VALUE_WIDTH-1:0]  s_tdata,
	// output stream; tdata: char_out[6:0], zero[7]; tlast: last
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [itrt_pkg::OUT_DATA_W-1:0]          m_tdata,
	output logic                                     m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_PUT
	} state_t;

	localparam int W = itrt_pkg::VALUE_WIDTH;

	state_t                          state_q;
	logic [itrt_pkg::RADIX_W-1:0]    radix_q;
	logic [W-1:0]                    quo_q;     // running quotient, shifted in place
	logic [itrt_pkg::DIGIT_W-1:0]    rem_q;     // partial remainder, always < radix
	logic [itrt_pkg::STEP_W-1:0]     step_q;
	logic [itrt_pkg::CNT_W-1:0]      cnt_q;     // digits stored / digits left to send
	logic                            neg_q;
	logic [itrt_pkg::DIGIT_W-1:0]    rd_q;      // registered store read
	logic                            m_tvalid_q;
	logic [itrt_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;

	// digit store, least significant digit first
	logic [itrt_pkg::DIGIT_W-1:0]    digit_store [W];

	logic [W-1:0]                    quo_nxt;
	logic [itrt_pkg::DIGIT_W-1:0]    rem_nxt;
	logic                            div_done;
	logic                            out_free;
	logic                            beat_load;
	logic                            accept;
	logic [itrt_pkg::CNT_W-1:0]      cnt_dec;
	logic [W-1:0]                    mag_in;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_dec  = cnt_q - 1'b1;
	assign div_done = (state_q == ST_DIV) && (step_q == itrt_pkg::STEP_W'(itrt_pkg::STEPS - 1));

	// a new beat enters the output register: minus sign or next digit
	assign beat_load = out_free && (((state_q == ST_SIGN) && neg_q) || (state_q == ST_PUT));

	// magnitude as unsigned negation; the most negative value maps to 2^(W-1)
	assign mag_in = s_tdata[W-1] ? (~s_tdata + 1'b1) : s_tdata;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	// Shared divider: BITS_PER_STEP restoring steps of (remainder, quotient) by radix.
	// Remainder stays below radix, so each trial value fits in DIGIT_W+1 bits.
	always_comb begin
		logic [itrt_pkg::DIGIT_W:0] trial;
		logic [W-1:0]               q;
		logic [itrt_pkg::DIGIT_W-1:0] r;
		q = quo_q;
		r = rem_q;
		for (int i = 0; i < itrt_pkg::BITS_PER_STEP; i++) begin
			trial = {r, q[W-1]};
			q     = {q[W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				trial = trial - {1'b0, radix_q};
				q[0]  = 1'b1;
			end
			r = trial[itrt_pkg::DIGIT_W-1:0];
		end
		quo_nxt = q;
		rem_nxt = r;
	end

	// radix register, saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itrt_pkg::RADIX_RESET;
		end else if (radix_we) begin
			if (radix_wdata < itrt_pkg::RADIX_MIN) begin
				radix_q <= itrt_pkg::RADIX_MIN;
			end else if (radix_wdata > itrt_pkg::RADIX_MAX) begin
				radix_q <= itrt_pkg::RADIX_MAX;
			end else begin
				radix_q <= radix_wdata;
			end
		end
	end

	// digit store: write at end of each digit, registered read while sending
	always_ff @(posedge clk) begin
		if (div_done) begin
			digit_store[cnt_q[itrt_pkg::IDX_W-1:0]] <= rem_nxt;
		end
		if (state_q == ST_RD) begin
			rd_q <= digit_store[cnt_dec[itrt_pkg::IDX_W-1:0]];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			quo_q      <= '0;
			rem_q      <= '0;
			step_q     <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			char_q     <= '0;
			last_q     <= 1'b0;
		end else begin
			if (beat_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= s_tdata[W-1];
						quo_q   <= mag_in;
						rem_q   <= '0;
						step_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= quo_nxt;
					if (div_done) begin
						// next digit starts over on the quotient with a clear remainder
						rem_q  <= '0;
						step_q <= '0;
						cnt_q  <= cnt_q + 1'b1;
						if (quo_nxt == '0) begin
							state_q <= ST_SIGN;
						end
					end else begin
						rem_q  <= rem_nxt;
						step_q <= step_q + 1'b1;
					end
				end
				ST_SIGN: begin
					if (!neg_q) begin
						state_q <= ST_RD;
					end else if (out_free) begin
						char_q  <= itrt_pkg::CHAR_MINUS;
						last_q  <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					cnt_q   <= cnt_dec;
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						char_q  <= itrt_pkg::glyph_of(rd_q);
						last_q  <= (cnt_q == '0);
						state_q <= (cnt_q == '0) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`ITRT_ASSERT_IMPLY(a_radix_range, 1'b1, (radix_q >= itrt_pkg::RADIX_MIN) && (radix_q <= itrt_pkg::RADIX_MAX), "radix register out of range")
	`ITRT_ASSERT_NEXT(a_accept_divides, accept, (state_q == ST_DIV) && (step_q == '0) && (cnt_q == '0), "accepted value did not start division")
	`ITRT_ASSERT_IMPLY(a_store_bound, state_q == ST_DIV, cnt_q < itrt_pkg::CNT_W'(W), "digit store index overflow")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the integer to radix text converter core.
`timescale 1ns / 100ps

module tb_top;

	typedef struct packed {
		logic [itrt_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} text_beat_t;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             radix_we    = 1'b0;
	logic [itrt_pkg::RADIX_W-1:0]     radix_wdata = '0;
	logic                             s_tvalid    = 1'b0;
	logic                             s_tready;
	logic [itrt_pkg::VALUE_WIDTH-1:0] s_tdata     = '0;
	logic                             m_tvalid;
	logic                             m_tready    = 1'b0;
	logic [itrt_pkg::OUT_DATA_W-1:0]  m_tdata;
	logic                             m_tlast;

	// expected characters, oldest first
	text_beat_t                   pending_chars[$];
	logic [itrt_pkg::RADIX_W-1:0] model_radix = itrt_pkg::RADIX_RESET;
	int                           err_count   = 0;
	bit                           idle_on     = 1'b1;
	int                           rdy_hold    = 0;

	integer_to_radix_text_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- model
	function automatic logic [itrt_pkg::RADIX_W-1:0] clamp_radix(
		input logic [itrt_pkg::RADIX_W-1:0] w);
		if (w < itrt_pkg::RADIX_MIN) begin
			return itrt_pkg::RADIX_MIN;
		end else if (w > itrt_pkg::RADIX_MAX) begin
			return itrt_pkg::RADIX_MAX;
		end
		return w;
	endfunction

	function automatic logic [itrt_pkg::CHAR_W-1:0] digit_char(
		input logic [itrt_pkg::DIGIT_W-1:0] d);
		logic [itrt_pkg::CHAR_W-1:0] d7;
		d7 = {1'b0, d};
		if (d < itrt_pkg::DEC_DIGITS) begin
			return itrt_pkg::CHAR_ZERO + d7;
		end
		return itrt_pkg::CHAR_A + d7 - {1'b0, itrt_pkg::DEC_DIGITS};
	endfunction

	// Digits are collected least significant first, then emitted in reverse.
	task automatic predict_text(input logic [itrt_pkg::VALUE_WIDTH-1:0] v,
		input logic [itrt_pkg::RADIX_W-1:0] r);
		logic [itrt_pkg::VALUE_WIDTH-1:0] rest;
		logic [itrt_pkg::DIGIT_W-1:0]     digs[itrt_pkg::VALUE_WIDTH];
		int                               n;
		text_beat_t                       b;
		n = 0;
		rest = v[itrt_pkg::VALUE_WIDTH-1] ? (~v + 1'b1) : v;
		do begin
			digs[n[itrt_pkg::IDX_W-1:0]] = itrt_pkg::DIGIT_W'(rest % r);
			n++;
			rest = rest / r;
		end while (rest != 0);
		if (v[itrt_pkg::VALUE_WIDTH-1]) begin
			b.ch = itrt_pkg::CHAR_MINUS;
			b.last = 1'b0;
			pending_chars.push_back(b);
		end
		while (n > 0) begin
			n--;
			b.ch = digit_char(digs[n[itrt_pkg::IDX_W-1:0]]);
			b.last = (n == 0);
			pending_chars.push_back(b);
		end
	endtask

	// -------------------------------------------------------------- checking
	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		err_count++;
	endtask

	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b", m_tdata, m_tlast));
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata[itrt_pkg::CHAR_W-1:0] !== want.ch)
					report_mismatch($sformatf("char %h, want %h",
						m_tdata[itrt_pkg::CHAR_W-1:0], want.ch));
				if (m_tdata[itrt_pkg::OUT_DATA_W-1] !== 1'b0)
					report_mismatch("tdata pad bit not zero");
				if (m_tlast !== want.last)
					report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
			end
		end
	end

	// random receiver back-pressure bursts, off while idle_on is clear
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (rdy_hold != 0) begin
			rdy_hold <= rdy_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			rdy_hold <= $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// -------------------------------------------------------------- stimulus
	// Valid stays high after a beat; the next send or a pause follows in the same step.
	task automatic send_value(input logic [itrt_pkg::VALUE_WIDTH-1:0] v);
		int gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_text(v, model_radix);
	endtask

	task automatic wait_text_drained();
		s_tvalid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// every value causes output, so an empty queue means the core is idle
	task automatic write_radix(input logic [itrt_pkg::RADIX_W-1:0] w);
		wait_text_drained();
		radix_we <= 1'b1;
		radix_wdata <= w;
		@(posedge clk);
		radix_we <= 1'b0;
		model_radix = clamp_radix(w);
	endtask

	function automatic logic [itrt_pkg::VALUE_WIDTH-1:0] pick_value();
		logic [itrt_pkg::VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h8000_0000 + $urandom_range(0, 3);
			1: v = 32'h7fff_ffff - $urandom_range(0, 3);
			2: v = $urandom_range(0, 40);
			3: v = -$urandom_range(0, 40);
			4: v = $urandom_range(0, 70000) * ($urandom_range(0, 1) ? 1 : -1);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [itrt_pkg::RADIX_W-1:0] pick_radix();
		case ($urandom_range(0, 5))
			0: return itrt_pkg::RADIX_W'($urandom_range(0, 2));
			1: return itrt_pkg::RADIX_W'($urandom_range(36, 63));
			default: return itrt_pkg::RADIX_W'($urandom_range(2, 36));
		endcase
	endfunction

	// ------------------------------------------------------------ test tasks
	task automatic test_reset_radix();
		send_value(32'd0);
		send_value(32'd255);
		send_value(32'h8000_0000);
		send_value(32'hffff_fff5);
	endtask

	task automatic test_decimal_edges();
		write_radix(6'd10);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hffff_ffff);
		send_value(32'h7fff_ffff);
		send_value(32'h8000_0000);
		send_value(32'd10);
		send_value(-32'sd10);
	endtask

	task automatic test_radix_saturation();
		write_radix(6'd0);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		send_value(32'd5);
		write_radix(6'd63);
		send_value(32'd35);
		send_value(32'd36);
		send_value(32'h8000_0000);
		write_radix(6'd1);
		send_value(32'hffff_ffff);
		write_radix(6'd37);
		send_value(32'h7fff_ffff);
		write_radix(6'd36);
		send_value(32'd1295);
		write_radix(6'd2);
		send_value(32'd0);
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				write_radix(pick_radix());
			// idle-free stretch in the middle
			idle_on = !(i >= count / 2 && i < count / 2 + 40);
			// sender holds off until all text is out
			if (i == count / 3)
				wait_text_drained();
			send_value(pick_value());
		end
		idle_on = 1'b1;
	endtask

	task automatic test_steady_stream(input int count);
		idle_on = 1'b0;
		write_radix(itrt_pkg::RADIX_W'($urandom_range(2, 36)));
		for (int i = 0; i < count; i++)
			send_value(pick_value());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_decimal_edges();
		test_radix_saturation();
		test_random_mix(320);
		test_steady_stream(60);
		wait_text_drained();
		repeat (40) @(posedge clk);
		if (err_count == 0 && pending_chars.size() == 0) begin
			$display("integer_to_radix_text_core test passed");
		end else begin
			$display("integer_to_radix_text_core test failed");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("integer_to_radix_text_core test failed");
		$finish;
	end

endmodule
